/* sv/bmw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmw_pkg;

    // 5x5 mask layout, bit row*5+col
    localparam int GRID      = 5;
    localparam int GRID_BITS = GRID * GRID;

    // register field widths
    localparam int MODE_W     = 2;
    localparam int THR_W      = 8;
    localparam int MASK_W     = 25;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAIN_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_MASK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_MASK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd6;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_DILATE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERODE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HITMISS = 2'd2;

    // input word codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // register values after reset
    localparam logic [MODE_W-1:0]   RST_MODE      = MODE_DILATE;
    localparam logic [THR_W-1:0]    RST_THRESHOLD = 8'd128;
    localparam logic [MASK_W-1:0]   RST_MAIN_MASK = 25'd15728622;
    localparam logic [MASK_W-1:0]   RST_HIT_MASK  = 25'd137216;
    localparam logic [MASK_W-1:0]   RST_MISS_MASK = 25'd8576;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH     = 11'd512;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT    = 13'd512;

    typedef struct packed {
        logic       op;
        logic [7:0] pixel_value;
    } t_in_word;

    typedef struct packed {
        logic out_pixel;
        logic out_last;
    } t_out_word;

    // position status of one accepted word
    typedef struct packed {
        logic            emit;
        logic            last;
        logic [GRID-1:0] row_ok;
        logic [GRID-1:0] col_ok;
    } t_pos_info;

    // mask bits within the given radius of the center
    function automatic logic [GRID_BITS-1:0] f_reach(input int radius);
        logic [GRID_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < GRID; i++) begin
            for (int j = 0; j < GRID; j++) begin
                if ((i - 2 <= radius) && (2 - i <= radius) &&
                    (j - 2 <= radius) && (2 - j <= radius)) begin
                    m[i * GRID + j] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* sv/bmw_line_buf.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmw_line_buf #(
    parameter int DEPTH = 1024,
    parameter int LINES = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [$clog2(DEPTH)-1:0] i_next_addr,
    input  wire logic                     i_bit,
    output logic      [LINES-1:0]         o_lines
);

    localparam int AW = $clog2(DEPTH);

    // one word per column, the newest row in the top bit
    logic [LINES-1:0] r_mem [DEPTH];
    logic [LINES-1:0] r_rd;
    logic [LINES-1:0] wr_word;

    // drop the oldest row, push the new bit
    assign wr_word = {i_bit, r_rd[LINES-1:1]};

    // write the current column, prefetch the next one; forward on same address
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= wr_word;
            if (i_next_addr == i_addr) begin
                r_rd <= wr_word;
            end else begin
                r_rd <= r_mem[i_next_addr[AW-1:0]];
            end
        end
    end

    assign o_lines = r_rd;

endmodule

`default_nettype wire

/* sv/bmw_pos.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmw_pos
    import bmw_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int RADIUS    = 2
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_adv,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   i_width,
    input  wire logic [HEIGHT_W-1:0]              i_height,
    output logic      [$clog2(MAX_WIDTH)-1:0]     o_col,
    output logic      [$clog2(MAX_WIDTH)-1:0]     o_next_col,
    output t_pos_info                             o_info
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);

    logic [CW-1:0]       r_in_col;
    logic [CW-1:0]       r_out_col;
    logic [HEIGHT_W-1:0] r_out_row;
    logic [LW-1:0]       r_lead;

    logic [CW-1:0]       n_in_col;
    logic [CW-1:0]       n_out_col;
    logic [HEIGHT_W-1:0] n_out_row;
    logic [LW-1:0]       n_lead;

    logic [LW-1:0] delay;
    logic          in_col_end;
    logic          out_col_end;
    t_pos_info     info;

    // words between the first input and the first result
    assign delay = LW'(i_width) * LW'(RADIUS) + LW'(RADIUS);

    assign in_col_end  = (32'(r_in_col) + 32'd1) >= 32'(i_width);
    assign out_col_end = (32'(r_out_col) + 32'd1) >= 32'(i_width);

    // status of the current word and in-image flags of the result window
    always_comb begin
        int row_pos;
        int col_pos;
        info.emit = (r_lead == delay);
        info.last = info.emit && out_col_end &&
                    ((32'(r_out_row) + 32'd1) == 32'(i_height));
        for (int k = 0; k < GRID; k++) begin
            row_pos = int'(r_out_row) + k - 2;
            col_pos = int'(r_out_col) + k - 2;
            info.row_ok[k] = (row_pos >= 0) && (row_pos < int'(i_height));
            info.col_ok[k] = (col_pos >= 0) && (col_pos < int'(i_width));
        end
    end

    // advance input and output positions
    always_comb begin
        n_in_col  = in_col_end ? '0 : r_in_col + CW'(1);
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lead    = r_lead;
        if (info.emit) begin
            n_out_col = out_col_end ? '0 : r_out_col + CW'(1);
            n_out_row = out_col_end ? r_out_row + HEIGHT_W'(1) : r_out_row;
        end else begin
            n_lead = r_lead + LW'(1);
        end
        // restart for the next image
        if (info.last) begin
            n_in_col  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lead    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_lead    <= '0;
        end else if (i_adv) begin
            r_in_col  <= n_in_col;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lead    <= n_lead;
        end
    end

    assign o_col      = r_in_col;
    assign o_next_col = n_in_col;
    assign o_info     = info;

endmodule

`default_nettype wire

/* sv/bmw_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmw_eval
    import bmw_pkg::*;
#(
    parameter int RADIUS = 2
) (
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [MASK_W-1:0]    i_main_mask,
    input  wire logic [MASK_W-1:0]    i_hit_mask,
    input  wire logic [MASK_W-1:0]    i_miss_mask,
    input  wire logic [GRID_BITS-1:0] i_win,
    input  wire logic [GRID_BITS-1:0] i_inside,
    output logic                      o_pixel
);

    localparam logic [GRID_BITS-1:0] LIM = f_reach(RADIUS);

    logic [GRID_BITS-1:0] fg;
    logic [GRID_BITS-1:0] bg;
    logic [GRID_BITS-1:0] fg_refl;
    logic [GRID_BITS-1:0] m_main;
    logic [GRID_BITS-1:0] m_hit;
    logic [GRID_BITS-1:0] m_miss;
    logic                 dil;
    logic                 ero;
    logic                 hm;

    // in-image foreground and background
    assign fg = i_win & i_inside;
    assign bg = ~i_win & i_inside;

    assign m_main = i_main_mask & LIM;
    assign m_hit  = i_hit_mask & LIM;
    assign m_miss = i_miss_mask & LIM;

    // reflect the window about its center
    always_comb begin
        for (int b = 0; b < GRID_BITS; b++) begin
            fg_refl[b] = fg[GRID_BITS - 1 - b];
        end
    end

    assign dil = |(m_main & fg_refl);
    assign ero = ~|(m_main & ~fg);
    assign hm  = (~|(m_hit & ~fg)) & (~|(m_miss & ~bg));

    always_comb begin
        case (i_mode)
            MODE_DILATE:  o_pixel = dil;
            MODE_ERODE:   o_pixel = ero;
            MODE_HITMISS: o_pixel = hm;
            default:      o_pixel = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/binary_morphology_window_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  | valid        | stall        | word
// ---------+--------------+--------------+----------------------------
// input    | i_in_valid   | o_in_stall   | i_in_word  (op, pixel_value)
// output   | o_out_valid  | i_out_stall  | o_out_word (out_pixel, out_last)
// config   | i_cfg_we     | none         | i_cfg_idx, i_cfg_data
//
// One input word per clock unless stalled. A result passes the window stage, then
// the output register, after the word completing its window; results start after
// R*W+R words (R half the window size, W the image width), the line buffer word
// per column read and written once per accepted word. Reset is synchronous: it
// clears positions, window and registers, not the line buffer. Input stalls only
// while a result waits in the window stage and in a stalled output register.

module binary_morphology_window_top
    import bmw_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int WINDOW_SIZE = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire t_in_word              i_in_word,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out_word                  o_out_word,
    input  wire logic                  i_out_stall,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int RADIUS = WINDOW_SIZE / 2;
    localparam int N      = 2 * RADIUS + 1;
    localparam int LINES  = 2 * RADIUS;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int OFS    = 2 - RADIUS;

    // configuration registers
    logic [MODE_W-1:0]   r_mode;
    logic [THR_W-1:0]    r_threshold;
    logic [MASK_W-1:0]   r_main_mask;
    logic [MASK_W-1:0]   r_hit_mask;
    logic [MASK_W-1:0]   r_miss_mask;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    logic [WW-1:0]       width_eff;
    logic [HEIGHT_W-1:0] height_eff;

    logic                accept;
    logic                s1_move;
    logic                fg_bit;
    logic [CW-1:0]       col;
    logic [CW-1:0]       next_col;
    t_pos_info           info;
    logic [LINES-1:0]    lines;

    // window stage
    logic [N-1:0]        r_win [N];
    logic                r_s1_valid;
    logic                r_s1_last;
    logic [GRID-1:0]     r_s1_row_ok;
    logic [GRID-1:0]     r_s1_col_ok;

    logic [GRID_BITS-1:0] win25;
    logic [GRID_BITS-1:0] inside25;
    logic                 res_pixel;

    // output register
    logic                r_out_valid;
    t_out_word           r_out_word;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_MODE;
            r_threshold <= RST_THRESHOLD;
            r_main_mask <= RST_MAIN_MASK;
            r_hit_mask  <= RST_HIT_MASK;
            r_miss_mask <= RST_MISS_MASK;
            r_width     <= RST_WIDTH;
            r_height    <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:      r_mode      <= i_cfg_data[MODE_W-1:0];
                REG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                REG_MAIN_MASK: r_main_mask <= i_cfg_data[MASK_W-1:0];
                REG_HIT_MASK:  r_hit_mask  <= i_cfg_data[MASK_W-1:0];
                REG_MISS_MASK: r_miss_mask <= i_cfg_data[MASK_W-1:0];
                REG_WIDTH:     r_width     <= i_cfg_data[WIDTH_W-1:0];
                REG_HEIGHT:    r_height    <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp image size
    always_comb begin
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
        height_eff = (r_height == '0) ? HEIGHT_W'(1) : r_height;
    end

    // handshake
    assign s1_move    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;

    // binarize; a flush stores background
    assign fg_bit = (i_in_word.op == OP_PIXEL) && (i_in_word.pixel_value >= r_threshold);

    bmw_pos #(
        .MAX_WIDTH (MAX_WIDTH),
        .RADIUS    (RADIUS)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (accept),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .o_col      (col),
        .o_next_col (next_col),
        .o_info     (info)
    );

    bmw_line_buf #(
        .DEPTH (MAX_WIDTH),
        .LINES (LINES)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_wr        (accept),
        .i_addr      (col),
        .i_next_addr (next_col),
        .i_bit       (fg_bit),
        .o_lines     (lines)
    );

    // shift the window by one column and capture the result position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) begin
                r_win[j] <= '0;
            end
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            for (int j = 0; j < N - 1; j++) begin
                r_win[j] <= r_win[j + 1];
            end
            r_win[N-1] <= {fg_bit, lines};
            r_s1_valid <= info.emit;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last   <= info.last;
            r_s1_row_ok <= info.row_ok;
            r_s1_col_ok <= info.col_ok;
        end
    end

    // place the window and in-image flags in the 5x5 layout
    always_comb begin
        win25    = '0;
        inside25 = '0;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                win25[(i + OFS) * GRID + (j + OFS)] = r_win[j][i];
            end
        end
        for (int i = 0; i < GRID; i++) begin
            for (int j = 0; j < GRID; j++) begin
                inside25[i * GRID + j] = r_s1_row_ok[i] & r_s1_col_ok[j];
            end
        end
    end

    bmw_eval #(
        .RADIUS (RADIUS)
    ) u_eval (
        .i_mode      (r_mode),
        .i_main_mask (r_main_mask),
        .i_hit_mask  (r_hit_mask),
        .i_miss_mask (r_miss_mask),
        .i_win       (win25),
        .i_inside    (inside25),
        .o_pixel     (res_pixel)
    );

    // output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_valid) begin
            r_out_word.out_pixel <= res_pixel;
            r_out_word.out_last  <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

/* sv/bmw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bmw_checker
    import bmw_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire t_out_word o_out_word,
    input wire logic      i_out_stall
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // stall input only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // a new result follows a word accepted earlier, through the window stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without an accepted word");

endmodule

bind binary_morphology_window_top bmw_checker u_bmw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
